[hdl/tccw_pkg.sv]
// Shared constants, types and command/status structs of the text console cell writer.
package tccw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 24;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned COPY_N  = CELLS - COLUMNS;

  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned COL_W   = $clog2(COLUMNS);
  localparam int unsigned CELL_W  = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_PAINT = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [8:0] NEWLINE_CODE = 9'd10;
  localparam logic [8:0] ERASE_CODE   = 9'h100;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LATCH,
    OP_PUT,
    OP_COPY,
    OP_BLANK,
    OP_PAINT,
    OP_READ,
    OP_CAPTURE,
    OP_RESP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   cnt_clr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_ok;
    logic       scroll;
    logic       clear_end;
    logic       copy_end;
    logic       blank_end;
    logic       paint_end;
  } status_t;

endpackage

[hdl/tccw_if.sv]
// Valid/ready channel interfaces for console items and results.
interface tccw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [8:0] char_code;
  logic [7:0] attribute;
  logic [10:0] cell_index;

  modport source (output valid, output mode, output char_code, output attribute,
                  output cell_index, input ready);
  modport sink   (input valid, input mode, input char_code, input attribute,
                  input cell_index, output ready);
endinterface

interface tccw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor;
  logic [15:0] cell_data;
  logic        scrolled;

  modport source (output valid, output cursor, output cell_data, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor, input cell_data, input scrolled,
                  output ready);
endinterface

[hdl/tccw_ram.sv]
// Generic simple dual-port RAM with registered read.
module tccw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hdl/tccw_dp.sv]
// Datapath: cell memory, cursor, sweep counter, item and result registers.
module tccw_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tccw_pkg::cmd_t    cmd_i,
  output tccw_pkg::status_t status_o,
  input  logic [1:0]        mode_i,
  input  logic [8:0]        char_code_i,
  input  logic [7:0]        attribute_i,
  input  logic [10:0]       cell_index_i,
  output logic [10:0]       cursor_o,
  output logic [15:0]       cell_data_o,
  output logic              scrolled_o
);

  // item fields
  logic [1:0]      mode_q;
  logic [8:0]      code_q;
  logic [7:0]      attr_q;
  logic [10:0]     idx_q;

  // cursor
  tccw_pkg::addr_t pos_q, pos_d;
  tccw_pkg::row_t  row_q, row_d;
  tccw_pkg::col_t  col_q, col_d;

  tccw_pkg::cnt_t  cnt_q, cnt_d;

  // pending write-back of a copy or repaint read
  logic            wb_q, wb_d;
  logic            wb_paint_q, wb_paint_d;
  tccw_pkg::addr_t wb_addr_q, wb_addr_d;

  tccw_pkg::cell_t data_q;
  logic            scrolled_q;

  logic            we, re;
  tccw_pkg::addr_t waddr, raddr, cnt_addr;
  tccw_pkg::cell_t wdata, rdata;

  logic is_nl, is_er, pos_zero, row_last, col_last, scroll;

  assign cnt_addr = tccw_pkg::addr_t'(cnt_q);
  assign is_nl    = (code_q == tccw_pkg::NEWLINE_CODE);
  assign is_er    = (code_q == tccw_pkg::ERASE_CODE);
  assign pos_zero = (pos_q == '0);
  assign row_last = (row_q == tccw_pkg::row_t'(tccw_pkg::ROWS - 1));
  assign col_last = (col_q == tccw_pkg::col_t'(tccw_pkg::COLUMNS - 1));
  assign scroll   = !is_er && row_last && (is_nl || col_last);

  always_comb begin
    status_o.mode      = mode_q;
    status_o.idx_ok    = (32'(idx_q) < 32'(tccw_pkg::CELLS));
    status_o.scroll    = scroll;
    status_o.clear_end = (cnt_q == tccw_pkg::cnt_t'(tccw_pkg::CELLS - 1));
    status_o.copy_end  = (cnt_q == tccw_pkg::cnt_t'(tccw_pkg::COPY_N));
    status_o.blank_end = (cnt_q == tccw_pkg::cnt_t'(tccw_pkg::COLUMNS - 1));
    status_o.paint_end = (cnt_q == tccw_pkg::cnt_t'(tccw_pkg::CELLS));
  end

  // cursor update for one put
  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.op == tccw_pkg::OP_PUT) begin
      if (scroll) begin
        pos_d = tccw_pkg::addr_t'(tccw_pkg::COPY_N);
        row_d = tccw_pkg::row_t'(tccw_pkg::ROWS - 1);
        col_d = '0;
      end else if (is_nl) begin
        pos_d = pos_q + tccw_pkg::addr_t'(tccw_pkg::COLUMNS) - tccw_pkg::addr_t'(col_q);
        row_d = row_q + 1'b1;
        col_d = '0;
      end else if (is_er) begin
        if (!pos_zero) begin
          pos_d = pos_q - 1'b1;
          if (col_q == '0) begin
            col_d = tccw_pkg::col_t'(tccw_pkg::COLUMNS - 1);
            row_d = row_q - 1'b1;
          end else begin
            col_d = col_q - 1'b1;
          end
        end
      end else begin
        pos_d = pos_q + 1'b1;
        if (col_last) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  // memory ports and sweep counter
  always_comb begin
    we         = 1'b0;
    waddr      = cnt_addr;
    wdata      = '0;
    re         = 1'b0;
    raddr      = cnt_addr;
    wb_d       = 1'b0;
    wb_paint_d = wb_paint_q;
    wb_addr_d  = wb_addr_q;
    cnt_d      = cnt_q;

    case (cmd_i.op)
      tccw_pkg::OP_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      tccw_pkg::OP_PUT: begin
        we    = !is_nl && !(is_er && pos_zero);
        waddr = is_er ? pos_q - 1'b1 : pos_q;
        wdata = is_er ? {attr_q, tccw_pkg::BLANK_CHAR} : {attr_q, code_q[7:0]};
      end
      tccw_pkg::OP_COPY: begin
        if (cnt_q < tccw_pkg::cnt_t'(tccw_pkg::COPY_N)) begin
          re         = 1'b1;
          raddr      = cnt_addr + tccw_pkg::addr_t'(tccw_pkg::COLUMNS);
          wb_d       = 1'b1;
          wb_paint_d = 1'b0;
          wb_addr_d  = cnt_addr;
        end
        cnt_d = cnt_q + 1'b1;
      end
      tccw_pkg::OP_BLANK: begin
        we    = 1'b1;
        waddr = tccw_pkg::addr_t'(tccw_pkg::COPY_N) + cnt_addr;
        wdata = {attr_q, tccw_pkg::BLANK_CHAR};
        cnt_d = cnt_q + 1'b1;
      end
      tccw_pkg::OP_PAINT: begin
        if (cnt_q < tccw_pkg::cnt_t'(tccw_pkg::CELLS)) begin
          re         = 1'b1;
          wb_d       = 1'b1;
          wb_paint_d = 1'b1;
          wb_addr_d  = cnt_addr;
        end
        cnt_d = cnt_q + 1'b1;
      end
      tccw_pkg::OP_READ: begin
        re    = 1'b1;
        raddr = tccw_pkg::addr_t'(idx_q);
      end
      default: ;
    endcase

    if (wb_q) begin
      we    = 1'b1;
      waddr = wb_addr_q;
      wdata = wb_paint_q ? {attr_q, rdata[7:0]} : rdata;
    end

    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      row_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
      wb_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
      wb_q  <= wb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_paint_q <= wb_paint_d;
    wb_addr_q  <= wb_addr_d;
    case (cmd_i.op)
      tccw_pkg::OP_LATCH: begin
        mode_q     <= mode_i;
        code_q     <= char_code_i;
        attr_q     <= attribute_i;
        idx_q      <= cell_index_i;
        data_q     <= '0;
        scrolled_q <= 1'b0;
      end
      tccw_pkg::OP_PUT: begin
        scrolled_q <= scroll;
      end
      tccw_pkg::OP_CAPTURE: begin
        data_q <= rdata;
      end
      tccw_pkg::OP_RESP: begin
        cursor_o    <= 11'(pos_q);
        cell_data_o <= data_q;
        scrolled_o  <= scrolled_q;
      end
      default: ;
    endcase
  end

  tccw_ram #(
    .WIDTH(tccw_pkg::CELL_W),
    .DEPTH(tccw_pkg::CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

[hdl/tccw_ctrl.sv]
// Controller: sequences clear, put, scroll, repaint and read over the datapath.
module tccw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tccw_pkg::status_t status_i,
  output tccw_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_DISPATCH = 10'b00_0000_0100,
    ST_PUT      = 10'b00_0000_1000,
    ST_COPY     = 10'b00_0001_0000,
    ST_BLANK    = 10'b00_0010_0000,
    ST_PAINT    = 10'b00_0100_0000,
    ST_READ     = 10'b00_1000_0000,
    ST_RDWAIT   = 10'b01_0000_0000,
    ST_RESP     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = tccw_pkg::OP_IDLE;
    cmd_o.cnt_clr = 1'b0;
    out_valid_d   = out_ready_i ? 1'b0 : out_valid_q;

    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = tccw_pkg::OP_CLEAR;
        if (status_i.clear_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op      = tccw_pkg::OP_LATCH;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.mode)
          tccw_pkg::MODE_PUT:   state_d = ST_PUT;
          tccw_pkg::MODE_PAINT: state_d = ST_PAINT;
          tccw_pkg::MODE_READ:  state_d = status_i.idx_ok ? ST_READ : ST_RESP;
          default:              state_d = ST_RESP;
        endcase
      end
      ST_PUT: begin
        cmd_o.op      = tccw_pkg::OP_PUT;
        cmd_o.cnt_clr = 1'b1;
        state_d       = status_i.scroll ? ST_COPY : ST_RESP;
      end
      ST_COPY: begin
        // final cycle only drains the last write-back
        cmd_o.op = tccw_pkg::OP_COPY;
        if (status_i.copy_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd_o.op = tccw_pkg::OP_BLANK;
        if (status_i.blank_end) begin
          state_d = ST_RESP;
        end
      end
      ST_PAINT: begin
        cmd_o.op = tccw_pkg::OP_PAINT;
        if (status_i.paint_end) begin
          state_d = ST_RESP;
        end
      end
      ST_READ: begin
        cmd_o.op = tccw_pkg::OP_READ;
        state_d  = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        cmd_o.op = tccw_pkg::OP_CAPTURE;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.op    = tccw_pkg::OP_RESP;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/text_console_cell_writer_unit.sv]
// Top level of the text console cell writer: controller, datapath and channels.
//
//   channel | dir | payload                               | transfer when
//   in_i    | in  | mode, char_code, attribute, cell_index | valid && ready
//   out_o   | out | cursor, cell_data, scrolled           | valid && ready
//
// A read past the last cell skips the memory read. A put that scrolls adds a copy
// pass that moves every row up by one and a pass that blanks the bottom row; a
// repaint sweeps every cell. The single cell memory port pair paces these passes.
// After reset a clearing pass writes every cell, with ready low.
// One item at a time; the next is taken while the previous result waits in the
// output register, and a stalled result holds the block before it answers again.
module text_console_cell_writer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tccw_in_if.sink    in_i,
  tccw_out_if.source out_o
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (in_i.mode),
    .char_code_i (in_i.char_code),
    .attribute_i (in_i.attribute),
    .cell_index_i(in_i.cell_index),
    .cursor_o    (out_o.cursor),
    .cell_data_o (out_o.cell_data),
    .scrolled_o  (out_o.scrolled)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the text console cell writer: directed and random items.
module tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned QUIET_ITEMS = 300;
  localparam int unsigned DRAIN_CYCLES = 2000;

  typedef struct packed {
    logic [10:0] cursor;
    logic [15:0] cell_data;
    logic        scrolled;
  } console_result_t;

  logic clk_i;
  logic rst_ni;

  tccw_in_if  item_if ();
  tccw_out_if result_if ();

  text_console_cell_writer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (result_if)
  );

  // shadow copy of the screen and cursor
  tccw_pkg::cell_t screen [tccw_pkg::CELLS];
  int unsigned     cur_pos;
  console_result_t expected_results [$];
  int              errors;
  bit              idle_on;
  int              stall_left;

  function automatic console_result_t console_apply(logic [1:0] mode, logic [8:0] code,
                                                    logic [7:0] attr, logic [10:0] idx);
    console_result_t r;
    int unsigned     pos;
    int unsigned     i;
    r = '0;
    case (mode)
      tccw_pkg::MODE_PUT: begin
        pos = cur_pos;
        if (pos >= tccw_pkg::CELLS) pos = 0;
        if (code == tccw_pkg::NEWLINE_CODE) begin
          pos += tccw_pkg::COLUMNS - pos % tccw_pkg::COLUMNS;
        end else if (code == tccw_pkg::ERASE_CODE) begin
          if (pos > 0) begin
            pos--;
            screen[pos] = {attr, tccw_pkg::BLANK_CHAR};
          end
        end else begin
          screen[pos] = {attr, code[7:0]};
          pos++;
        end
        // cursor fell off the bottom row: scroll up and blank from the cursor on
        if (pos / tccw_pkg::COLUMNS >= tccw_pkg::ROWS) begin
          for (i = 0; i < tccw_pkg::COPY_N; i++) screen[i] = screen[i + tccw_pkg::COLUMNS];
          pos -= tccw_pkg::COLUMNS;
          for (i = pos; i < tccw_pkg::CELLS; i++) screen[i] = {attr, tccw_pkg::BLANK_CHAR};
          r.scrolled = 1'b1;
        end
        cur_pos = pos;
      end
      tccw_pkg::MODE_PAINT: begin
        for (i = 0; i < tccw_pkg::CELLS; i++) screen[i][15:8] = attr;
      end
      tccw_pkg::MODE_READ: begin
        if (idx < tccw_pkg::CELLS) r.cell_data = screen[idx];
      end
      default: ;
    endcase
    r.cursor = cur_pos[10:0];
    return r;
  endfunction

  // one transfer on the item channel; called at a falling edge, returns at one
  task automatic send_item(logic [1:0] mode, logic [8:0] code, logic [7:0] attr,
                           logic [10:0] idx);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    expected_results.push_back(console_apply(mode, code, attr, idx));
    item_if.valid      <= 1'b1;
    item_if.mode       <= mode;
    item_if.char_code  <= code;
    item_if.attribute  <= attr;
    item_if.cell_index <= idx;
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [8:0] next_glyph();
    if ($urandom_range(0, 3) != 0) return 9'($urandom_range(8'h20, 8'h7e));
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic test_reset_state();
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'd0);
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'(tccw_pkg::CELLS - 1));
    // backspace with the cursor at the origin does nothing
    send_item(tccw_pkg::MODE_PUT, tccw_pkg::ERASE_CODE, 8'hff, 11'd0);
  endtask

  task automatic test_put_codes();
    send_item(tccw_pkg::MODE_PUT, 9'd0, 8'h00, 11'd0);
    send_item(tccw_pkg::MODE_PUT, 9'd255, 8'hff, 11'h7ff);
    send_item(tccw_pkg::MODE_PUT, 9'h101, 8'h5a, 11'd0);
    send_item(tccw_pkg::MODE_PUT, 9'h1ff, 8'ha5, 11'd0);
    send_item(tccw_pkg::MODE_PUT, tccw_pkg::ERASE_CODE, 8'h3c, 11'd0);
    send_item(tccw_pkg::MODE_PUT, tccw_pkg::NEWLINE_CODE, 8'h00, 11'd0);
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'd2);
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'd3);
  endtask

  task automatic test_read_range();
    send_item(tccw_pkg::MODE_READ, 9'h1ff, 8'hff, 11'(tccw_pkg::CELLS));
    send_item(tccw_pkg::MODE_READ, 9'h1ff, 8'hff, 11'h7ff);
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'd1);
  endtask

  task automatic test_repaint();
    send_item(tccw_pkg::MODE_PAINT, 9'h1ff, 8'hff, 11'h7ff);
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'd1);
    send_item(tccw_pkg::MODE_PAINT, 9'd0, 8'h00, 11'd0);
    send_item(tccw_pkg::MODE_READ, 9'd0, 8'h00, 11'd0);
  endtask

  task automatic test_unused_mode();
    send_item(MODE_UNUSED, 9'h1ff, 8'hff, 11'h7ff);
    send_item(MODE_UNUSED, 9'd0, 8'h00, 11'd0);
  endtask

  // mostly lines of text ending in newlines, mixed with reads, repaints and noise
  task automatic test_random_session();
    int          sent;
    int          pick;
    int          len;
    int          k;
    int unsigned near;
    logic [7:0]  attr;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = (sent < RANDOM_ITEMS - QUIET_ITEMS);
      pick = $urandom_range(0, 99);
      attr = 8'($urandom);
      if (pick < 40) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 20);
        for (k = 0; k < len; k++) begin
          send_item(tccw_pkg::MODE_PUT,
                    ($urandom_range(0, 11) == 0) ? tccw_pkg::ERASE_CODE : next_glyph(),
                    attr, 11'($urandom_range(0, 2047)));
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_item(tccw_pkg::MODE_PUT, tccw_pkg::NEWLINE_CODE, attr,
                    11'($urandom_range(0, 2047)));
          sent++;
        end
      end else if (pick < 80) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          near = cur_pos - $urandom_range(0, 3);
          if (near >= tccw_pkg::CELLS) near = 0;
          send_item(tccw_pkg::MODE_READ, 9'($urandom_range(0, 511)), 8'($urandom),
                    ($urandom_range(0, 1) == 0) ? 11'(near) : 11'($urandom_range(0, 2047)));
          sent++;
        end
      end else if (pick < 85) begin
        // erase run, may cross back into the previous row
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) begin
          send_item(tccw_pkg::MODE_PUT, tccw_pkg::ERASE_CODE, attr,
                    11'($urandom_range(0, 2047)));
          sent++;
        end
      end else if (pick < 90) begin
        send_item(tccw_pkg::MODE_PAINT, 9'($urandom_range(0, 511)), attr,
                  11'($urandom_range(0, 2047)));
        sent++;
      end else if (pick < 94) begin
        send_item(MODE_UNUSED, 9'($urandom_range(0, 511)), attr, 11'($urandom_range(0, 2047)));
        sent++;
      end else begin
        send_item(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), attr,
                  11'($urandom_range(0, 2047)));
        sent++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    console_result_t exp_r;
    if (result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: cursor %0d cell_data %h scrolled %0b",
                 $time, result_if.cursor, result_if.cell_data, result_if.scrolled);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_if.cursor !== exp_r.cursor) begin
          $display("%0t: cursor mismatch: expected %0d, actual %0d",
                   $time, exp_r.cursor, result_if.cursor);
          errors++;
        end
        if (result_if.cell_data !== exp_r.cell_data) begin
          $display("%0t: cell_data mismatch: expected %h, actual %h",
                   $time, exp_r.cell_data, result_if.cell_data);
          errors++;
        end
        if (result_if.scrolled !== exp_r.scrolled) begin
          $display("%0t: scrolled mismatch: expected %0b, actual %0b",
                   $time, exp_r.scrolled, result_if.scrolled);
          errors++;
        end
      end
    end
  end

  initial begin
    #400_000_000;
    $display("** text_console_cell_writer_unit: FAILED **");
    $finish;
  end

  initial begin
    errors     = 0;
    idle_on    = 1'b1;
    stall_left = 0;
    cur_pos    = 0;
    foreach (screen[i]) screen[i] = '0;
    rst_ni               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.mode         = tccw_pkg::MODE_PUT;
    item_if.char_code    = '0;
    item_if.attribute    = '0;
    item_if.cell_index   = '0;
    result_if.ready      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_put_codes();
    test_read_range();
    test_repaint();
    test_unused_mode();
    test_random_session();

    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("** text_console_cell_writer_unit: PASSED **");
    end else begin
      $display("** text_console_cell_writer_unit: FAILED **");
    end
    $finish;
  end

endmodule

[text_console_cell_writer_unit.f]
hdl/tccw_pkg.sv
hdl/tccw_if.sv
hdl/tccw_ram.sv
hdl/tccw_dp.sv
hdl/tccw_ctrl.sv
hdl/text_console_cell_writer_unit.sv
verif/tb.sv
